### hdl/cllm_pkg.sv
`default_nettype none
package cllm_pkg;

    localparam int DEF_POOL_SIZE     = 64;
    localparam int DEF_ELEMENT_WIDTH = 32;

    localparam int CMD_W      = 2;
    localparam int POS_W      = 6;
    localparam int VAL_W      = 32;
    localparam int CNT_W      = 6;
    localparam int PC_W       = 4;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 64;

    localparam logic [CMD_W-1:0] CMD_CREATE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FREE   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd3;

    localparam logic [1:0] NRA_ZERO  = 2'd0;
    localparam logic [1:0] NRA_RDATA = 2'd1;
    localparam logic [1:0] NRA_POS   = 2'd2;

    localparam logic [1:0] NWA_ZERO = 2'd0;
    localparam logic [1:0] NWA_N    = 2'd1;
    localparam logic [1:0] NWA_POS  = 2'd2;

    localparam logic [1:0] NWD_RDATA = 2'd0;
    localparam logic [1:0] NWD_T     = 2'd1;
    localparam logic [1:0] NWD_N     = 2'd2;
    localparam logic [1:0] NWD_POS   = 2'd3;

    localparam logic PWA_T   = 1'b0;
    localparam logic PWA_N   = 1'b1;
    localparam logic PWD_N   = 1'b0;
    localparam logic PWD_POS = 1'b1;

    localparam logic [1:0] LST_NONE   = 2'd0;
    localparam logic [1:0] LST_CREATE = 2'd1;
    localparam logic [1:0] LST_INSERT = 2'd2;

    localparam logic [1:0] ON_POS  = 2'd0;
    localparam logic [1:0] ON_N    = 2'd1;
    localparam logic [1:0] ON_FAIL = 2'd2;

    localparam logic [1:0] J_NONE   = 2'd0;
    localparam logic [1:0] J_ZERO   = 2'd1;
    localparam logic [1:0] J_CREATE = 2'd2;

    localparam logic [PC_W-1:0] PC_ALLOC      = 4'd0;
    localparam logic [PC_W-1:0] PC_TAKE       = 4'd1;
    localparam logic [PC_W-1:0] PC_UNCHAIN    = 4'd2;
    localparam logic [PC_W-1:0] PC_LINK       = 4'd3;
    localparam logic [PC_W-1:0] PC_INSERT_END = 4'd4;
    localparam logic [PC_W-1:0] PC_CREATE_END = 4'd5;
    localparam logic [PC_W-1:0] PC_FAIL       = 4'd6;
    localparam logic [PC_W-1:0] PC_FREE       = 4'd7;
    localparam logic [PC_W-1:0] PC_FREE_LINK  = 4'd8;
    localparam logic [PC_W-1:0] PC_FREE_END   = 4'd9;
    localparam logic [PC_W-1:0] PC_READ       = 4'd10;
    localparam logic [PC_W-1:0] PC_READ_END   = 4'd11;

    typedef struct packed {
        logic [1:0]      nra;
        logic            nwe;
        logic [1:0]      nwa;
        logic [1:0]      nwd;
        logic            pwe;
        logic            pwa;
        logic            pwd;
        logic            ewe;
        logic            cap_n;
        logic            cap_f;
        logic [1:0]      lst;
        logic [1:0]      onode;
        logic            ostat;
        logic            oread;
        logic [1:0]      jmp;
        logic [PC_W-1:0] target;
        logic            last;
    } ucode_t;

    typedef struct packed {
        ucode_t uc;
        logic   go;
        logic   is_create;
    } ctrl_t;

    typedef struct packed {
        logic rd_zero;
        logic out_free;
    } dp_stat_t;

    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        w = '0;
        unique case (pc)
            PC_ALLOC: begin
                w.nra = NRA_ZERO;
            end
            PC_TAKE: begin
                w.nra    = NRA_RDATA;
                w.cap_n  = 1'b1;
                w.jmp    = J_ZERO;
                w.target = PC_FAIL;
            end
            PC_UNCHAIN: begin
                w.cap_f  = 1'b1;
                w.nwe    = 1'b1;
                w.nwa    = NWA_ZERO;
                w.nwd    = NWD_RDATA;
                w.nra    = NRA_POS;
                w.jmp    = J_CREATE;
                w.target = PC_CREATE_END;
            end
            PC_LINK: begin
                w.nwe = 1'b1;
                w.nwa = NWA_N;
                w.nwd = NWD_T;
                w.ewe = 1'b1;
                w.pwe = 1'b1;
                w.pwa = PWA_T;
                w.pwd = PWD_N;
            end
            PC_INSERT_END: begin
                w.nwe   = 1'b1;
                w.nwa   = NWA_POS;
                w.nwd   = NWD_N;
                w.pwe   = 1'b1;
                w.pwa   = PWA_N;
                w.pwd   = PWD_POS;
                w.lst   = LST_INSERT;
                w.onode = ON_N;
                w.last  = 1'b1;
            end
            PC_CREATE_END: begin
                w.nwe   = 1'b1;
                w.nwa   = NWA_N;
                w.nwd   = NWD_N;
                w.pwe   = 1'b1;
                w.pwa   = PWA_N;
                w.pwd   = PWD_N;
                w.lst   = LST_CREATE;
                w.onode = ON_N;
                w.last  = 1'b1;
            end
            PC_FAIL: begin
                w.onode = ON_FAIL;
                w.ostat = 1'b1;
                w.last  = 1'b1;
            end
            PC_FREE: begin
                w.nra = NRA_ZERO;
            end
            PC_FREE_LINK: begin
                w.nwe = 1'b1;
                w.nwa = NWA_POS;
                w.nwd = NWD_RDATA;
            end
            PC_FREE_END: begin
                w.nwe   = 1'b1;
                w.nwa   = NWA_ZERO;
                w.nwd   = NWD_POS;
                w.onode = ON_POS;
                w.last  = 1'b1;
            end
            PC_READ: begin
                w.nra = NRA_POS;
            end
            PC_READ_END: begin
                w.nra   = NRA_POS;
                w.oread = 1'b1;
                w.onode = ON_POS;
                w.last  = 1'b1;
            end
            default: begin
                w.onode = ON_POS;
                w.last  = 1'b1;
            end
        endcase
        return w;
    endfunction

    function automatic logic [PC_W-1:0] entry_pc(input logic [CMD_W-1:0] cmd);
        logic [PC_W-1:0] pc;
        unique case (cmd)
            CMD_CREATE: pc = PC_ALLOC;
            CMD_INSERT: pc = PC_ALLOC;
            CMD_FREE:   pc = PC_FREE;
            CMD_READ:   pc = PC_READ;
            default:    pc = PC_READ;
        endcase
        return pc;
    endfunction

endpackage
`default_nettype wire

### hdl/cursor_linked_list_manager.sv
// Cursor linked list manager: one list kept in a pool of POOL_SIZE nodes,
// with a free list headed by node 0.
// Input stream: s_tuser carries the command (create, insert after, free,
// read); s_tdata carries the node position and the value to insert.
// Output stream: one result beat per command, with status, node index,
// read-back element and links, list-empty and is-last flags and the count.
// Each command runs as a short program from the microcode table, one step
// per cycle (the last step waits for a free output register) over three
// pool memories with one read and one write port. The next beat is accepted
// the cycle after the last step, so one command is in flight at a time.
// After reset the pool is initialized in a pass over every node with
// s_tready low; the free list then chains every node and the list is empty.
// When the receiver stalls, a finished result holds in the output register
// while a new command may be taken; that command holds at its last step
// until the output register drains.
`default_nettype none
module cursor_linked_list_manager #(
    parameter int POOL_SIZE     = cllm_pkg::DEF_POOL_SIZE,
    parameter int ELEMENT_WIDTH = cllm_pkg::DEF_ELEMENT_WIDTH
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // position[5:0], value[37:6], zero fill [39:38]
    input  wire logic [cllm_pkg::IN_DATA_W-1:0]     s_tdata,
    // command[1:0]
    input  wire logic [cllm_pkg::CMD_W-1:0]         s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // status[0], node_index[6:1], element_value[38:7], prev_node[44:39],
    // next_node[50:45], list_empty[51], position_is_last[52],
    // element_count[58:53], zero fill [63:59]
    output logic [cllm_pkg::OUT_DATA_W-1:0]         m_tdata
);

    cllm_pkg::ctrl_t                ctrl;
    cllm_pkg::dp_stat_t             stat;
    logic                           busy;
    logic                           clearing;
    logic                           start;
    logic                           status;
    logic [cllm_pkg::POS_W-1:0]     node_index;
    logic [cllm_pkg::VAL_W-1:0]     element_value;
    logic [cllm_pkg::POS_W-1:0]     prev_node;
    logic [cllm_pkg::POS_W-1:0]     next_node;
    logic                           list_empty;
    logic                           position_is_last;
    logic [cllm_pkg::CNT_W-1:0]     element_count;

    assign s_tready = ~busy & ~clearing;
    assign start    = s_tvalid & s_tready;

    cllm_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .cmd     (s_tuser),
        .stat    (stat),
        .ctrl    (ctrl),
        .busy    (busy)
    );

    cllm_dpath #(
        .POOL_SIZE     (POOL_SIZE),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_dpath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .start              (start),
        .in_position        (s_tdata[5:0]),
        .in_value           (s_tdata[37:6]),
        .ctrl               (ctrl),
        .m_ready            (m_tready),
        .stat               (stat),
        .clearing           (clearing),
        .m_valid            (m_tvalid),
        .o_status           (status),
        .o_node_index       (node_index),
        .o_element_value    (element_value),
        .o_prev_node        (prev_node),
        .o_next_node        (next_node),
        .o_list_empty       (list_empty),
        .o_position_is_last (position_is_last),
        .o_element_count    (element_count)
    );

    assign m_tdata = {5'b0, element_count, position_is_last, list_empty, next_node,
                      prev_node, element_value, node_index, status};

endmodule
`default_nettype wire

### hdl/cllm_ram.sv
`default_nettype none
module cllm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

### hdl/cllm_seq.sv
`default_nettype none
module cllm_seq (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [cllm_pkg::CMD_W-1:0]  cmd,
    input  wire cllm_pkg::dp_stat_t          stat,
    output cllm_pkg::ctrl_t                  ctrl,
    output logic                             busy
);

    logic [cllm_pkg::PC_W-1:0]  pc_reg, pc_next;
    logic                       busy_reg, busy_next;
    logic                       create_reg, create_next;
    cllm_pkg::ucode_t           uc;
    logic                       go;
    logic                       taken;

    always_comb begin
        uc = cllm_pkg::ucode_rom(pc_reg);
        go = busy_reg & (~uc.last | stat.out_free);
        priority case (uc.jmp)
            cllm_pkg::J_ZERO:   taken = stat.rd_zero;
            cllm_pkg::J_CREATE: taken = create_reg;
            default:            taken = 1'b0;
        endcase
    end

    always_comb begin
        pc_next     = pc_reg;
        busy_next   = busy_reg;
        create_next = create_reg;
        if (start) begin
            pc_next     = cllm_pkg::entry_pc(cmd);
            busy_next   = 1'b1;
            create_next = (cmd == cllm_pkg::CMD_CREATE);
        end else if (go) begin
            if (uc.last) begin
                busy_next = 1'b0;
            end else if (taken) begin
                pc_next = uc.target;
            end else begin
                pc_next = pc_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg     <= cllm_pkg::PC_ALLOC;
            busy_reg   <= 1'b0;
            create_reg <= 1'b0;
        end else begin
            pc_reg     <= pc_next;
            busy_reg   <= busy_next;
            create_reg <= create_next;
        end
    end

    assign ctrl.uc        = uc;
    assign ctrl.go        = go;
    assign ctrl.is_create = create_reg;
    assign busy           = busy_reg;

endmodule
`default_nettype wire

### hdl/cllm_dpath.sv
`default_nettype none
module cllm_dpath #(
    parameter int POOL_SIZE     = cllm_pkg::DEF_POOL_SIZE,
    parameter int ELEMENT_WIDTH = cllm_pkg::DEF_ELEMENT_WIDTH
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [cllm_pkg::POS_W-1:0]  in_position,
    input  wire logic [cllm_pkg::VAL_W-1:0]  in_value,
    input  wire cllm_pkg::ctrl_t             ctrl,
    input  wire logic                        m_ready,
    output cllm_pkg::dp_stat_t               stat,
    output logic                             clearing,
    output logic                             m_valid,
    output logic                             o_status,
    output logic [cllm_pkg::POS_W-1:0]       o_node_index,
    output logic [cllm_pkg::VAL_W-1:0]       o_element_value,
    output logic [cllm_pkg::POS_W-1:0]       o_prev_node,
    output logic [cllm_pkg::POS_W-1:0]       o_next_node,
    output logic                             o_list_empty,
    output logic                             o_position_is_last,
    output logic [cllm_pkg::CNT_W-1:0]       o_element_count
);

    localparam int AW = $clog2(POOL_SIZE);
    localparam logic [AW-1:0] LAST_IDX = AW'(POOL_SIZE - 1);

    logic [AW-1:0]                     pos_in;
    logic [AW-1:0]                     pos_reg, pos_next;
    logic [cllm_pkg::VAL_W-1:0]        val_reg, val_next;
    logic [AW-1:0]                     n_reg, n_next;
    logic [AW-1:0]                     f_reg, f_next;
    logic [AW-1:0]                     head_reg, head_next;
    logic [AW-1:0]                     last_reg, last_next;
    logic [cllm_pkg::CNT_W-1:0]        count_reg, count_next;
    logic [AW-1:0]                     clr_reg, clr_next;
    logic                              clr_busy_reg, clr_busy_next;
    logic                              valid_reg, valid_next;

    logic                              st_reg, st_next;
    logic [cllm_pkg::POS_W-1:0]        node_reg, node_next;
    logic [cllm_pkg::VAL_W-1:0]        elem_out_reg, elem_out_next;
    logic [cllm_pkg::POS_W-1:0]        prev_out_reg, prev_out_next;
    logic [cllm_pkg::POS_W-1:0]        next_out_reg, next_out_next;
    logic                              empty_reg, empty_next;
    logic                              is_last_reg, is_last_next;
    logic [cllm_pkg::CNT_W-1:0]        cnt_out_reg, cnt_out_next;

    logic                              nxt_we;
    logic [AW-1:0]                     nxt_wa, nxt_wd, nxt_ra, nxt_rd;
    logic                              prv_we;
    logic [AW-1:0]                     prv_wa, prv_wd, prv_rd;
    logic                              elm_we;
    logic [AW-1:0]                     elm_wa;
    logic [ELEMENT_WIDTH-1:0]          elm_wd, elm_rd;
    logic [AW-1:0]                     t_val;
    logic                              emit;
    cllm_pkg::ucode_t                  uc;

    always_comb begin
        pos_in = '0;
        for (int k = 0; k < 64; k++) begin
            if (in_position == cllm_pkg::POS_W'(k)) begin
                pos_in = AW'(k % POOL_SIZE);
            end
        end
    end

    assign uc    = ctrl.uc;
    assign t_val = (pos_reg == '0) ? f_reg : nxt_rd;
    assign emit  = ctrl.go & uc.last;

    always_comb begin
        unique case (uc.nra)
            cllm_pkg::NRA_RDATA: nxt_ra = nxt_rd;
            cllm_pkg::NRA_POS:   nxt_ra = pos_reg;
            default:             nxt_ra = '0;
        endcase
        if (clr_busy_reg) begin
            nxt_we = 1'b1;
            nxt_wa = clr_reg;
            nxt_wd = (clr_reg == LAST_IDX) ? '0 : clr_reg + 1'b1;
            prv_we = 1'b1;
            prv_wa = clr_reg;
            prv_wd = '0;
            elm_we = 1'b1;
            elm_wa = clr_reg;
            elm_wd = '0;
        end else begin
            nxt_we = ctrl.go & uc.nwe;
            unique case (uc.nwa)
                cllm_pkg::NWA_N:   nxt_wa = n_reg;
                cllm_pkg::NWA_POS: nxt_wa = pos_reg;
                default:           nxt_wa = '0;
            endcase
            unique case (uc.nwd)
                cllm_pkg::NWD_T:   nxt_wd = t_val;
                cllm_pkg::NWD_N:   nxt_wd = n_reg;
                cllm_pkg::NWD_POS: nxt_wd = pos_reg;
                default:           nxt_wd = nxt_rd;
            endcase
            prv_we = ctrl.go & uc.pwe;
            prv_wa = (uc.pwa == cllm_pkg::PWA_N) ? n_reg
                   : ((pos_reg == n_reg) ? n_reg : t_val);
            prv_wd = (uc.pwd == cllm_pkg::PWD_POS) ? pos_reg : n_reg;
            elm_we = ctrl.go & uc.ewe;
            elm_wa = n_reg;
            elm_wd = ELEMENT_WIDTH'($unsigned(val_reg));
        end
    end

    cllm_ram #(.WIDTH(AW), .DEPTH(POOL_SIZE)) u_next_ram (
        .aclk  (aclk),
        .we    (nxt_we),
        .waddr (nxt_wa),
        .wdata (nxt_wd),
        .raddr (nxt_ra),
        .rdata (nxt_rd)
    );

    cllm_ram #(.WIDTH(AW), .DEPTH(POOL_SIZE)) u_prev_ram (
        .aclk  (aclk),
        .we    (prv_we),
        .waddr (prv_wa),
        .wdata (prv_wd),
        .raddr (pos_reg),
        .rdata (prv_rd)
    );

    cllm_ram #(.WIDTH(ELEMENT_WIDTH), .DEPTH(POOL_SIZE)) u_elem_ram (
        .aclk  (aclk),
        .we    (elm_we),
        .waddr (elm_wa),
        .wdata (elm_wd),
        .raddr (pos_reg),
        .rdata (elm_rd)
    );

    always_comb begin
        pos_next      = start ? pos_in : pos_reg;
        val_next      = start ? in_value : val_reg;
        n_next        = (ctrl.go & uc.cap_n) ? nxt_rd : n_reg;
        f_next        = (ctrl.go & uc.cap_f) ? nxt_rd : f_reg;
        clr_busy_next = clr_busy_reg & (clr_reg != LAST_IDX);
        clr_next      = clr_busy_reg ? clr_reg + 1'b1 : clr_reg;

        head_next  = head_reg;
        last_next  = last_reg;
        count_next = count_reg;
        if (ctrl.go) begin
            priority case (uc.lst)
                cllm_pkg::LST_CREATE: begin
                    head_next  = n_reg;
                    last_next  = n_reg;
                    count_next = '0;
                end
                cllm_pkg::LST_INSERT: begin
                    if (last_reg == pos_reg) begin
                        last_next = n_reg;
                    end
                    count_next = count_reg + 1'b1;
                end
                default: begin
                end
            endcase
        end

        valid_next    = valid_reg & ~m_ready;
        st_next       = st_reg;
        node_next     = node_reg;
        elem_out_next = elem_out_reg;
        prev_out_next = prev_out_reg;
        next_out_next = next_out_reg;
        empty_next    = empty_reg;
        is_last_next  = is_last_reg;
        cnt_out_next  = cnt_out_reg;
        if (emit) begin
            valid_next = 1'b1;
            st_next    = uc.ostat;
            unique case (uc.onode)
                cllm_pkg::ON_N:    node_next = cllm_pkg::POS_W'(n_reg);
                cllm_pkg::ON_FAIL: node_next = ctrl.is_create ? '0
                                                              : cllm_pkg::POS_W'(pos_reg);
                default:           node_next = cllm_pkg::POS_W'(pos_reg);
            endcase
            if (uc.oread) begin
                elem_out_next = cllm_pkg::VAL_W'($signed(elm_rd));
                prev_out_next = cllm_pkg::POS_W'(prv_rd);
                next_out_next = cllm_pkg::POS_W'(nxt_rd);
            end else begin
                elem_out_next = '0;
                prev_out_next = '0;
                next_out_next = '0;
            end
            empty_next   = (head_next == last_next);
            is_last_next = (last_next == pos_reg);
            cnt_out_next = count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg     <= '0;
            last_reg     <= '0;
            count_reg    <= '0;
            clr_reg      <= '0;
            clr_busy_reg <= 1'b1;
            valid_reg    <= 1'b0;
        end else begin
            head_reg     <= head_next;
            last_reg     <= last_next;
            count_reg    <= count_next;
            clr_reg      <= clr_next;
            clr_busy_reg <= clr_busy_next;
            valid_reg    <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg      <= pos_next;
        val_reg      <= val_next;
        n_reg        <= n_next;
        f_reg        <= f_next;
        st_reg       <= st_next;
        node_reg     <= node_next;
        elem_out_reg <= elem_out_next;
        prev_out_reg <= prev_out_next;
        next_out_reg <= next_out_next;
        empty_reg    <= empty_next;
        is_last_reg  <= is_last_next;
        cnt_out_reg  <= cnt_out_next;
    end

    assign stat.rd_zero        = (nxt_rd == '0);
    assign stat.out_free       = ~valid_reg | m_ready;
    assign clearing            = clr_busy_reg;
    assign m_valid             = valid_reg;
    assign o_status            = st_reg;
    assign o_node_index        = node_reg;
    assign o_element_value     = elem_out_reg;
    assign o_prev_node         = prev_out_reg;
    assign o_next_node         = next_out_reg;
    assign o_list_empty        = empty_reg;
    assign o_position_is_last  = is_last_reg;
    assign o_element_count     = cnt_out_reg;

endmodule
`default_nettype wire

### test/tb_top.sv
module tb_top;

    localparam int NODES         = cllm_pkg::DEF_POOL_SIZE;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 12;
    localparam int MAX_REPORTS   = 40;

    typedef struct packed {
        logic                       status;
        logic [cllm_pkg::POS_W-1:0] node;
        logic [cllm_pkg::VAL_W-1:0] elem;
        logic [cllm_pkg::POS_W-1:0] prv;
        logic [cllm_pkg::POS_W-1:0] nxt;
        logic                       empty;
        logic                       is_last;
        logic [cllm_pkg::CNT_W-1:0] count;
    } list_result_t;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [cllm_pkg::IN_DATA_W-1:0]  s_tdata;
    logic [cllm_pkg::CMD_W-1:0]      s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [cllm_pkg::OUT_DATA_W-1:0] m_tdata;

    logic [cllm_pkg::POS_W-1:0] pool_next [NODES];
    logic [cllm_pkg::POS_W-1:0] pool_prev [NODES];
    logic [cllm_pkg::VAL_W-1:0] pool_elem [NODES];
    logic [cllm_pkg::POS_W-1:0] head_node;
    logic [cllm_pkg::POS_W-1:0] last_node;
    logic [cllm_pkg::CNT_W-1:0] elem_count;

    list_result_t               pending_results [$];
    logic [cllm_pkg::POS_W-1:0] live_nodes [$];
    list_result_t               want_beat;

    int errors;
    int cmds_sent;
    int results_checked;
    int refused_allocs;
    int send_idle_pct;
    int recv_stall_pct;
    int cycles;

    cursor_linked_list_manager uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic void reset_pool_model();
        for (int i = 0; i < NODES; i++) begin
            pool_next[i] = cllm_pkg::POS_W'((i + 1) % NODES);
            pool_prev[i] = '0;
            pool_elem[i] = '0;
        end
        head_node  = '0;
        last_node  = '0;
        elem_count = '0;
    endfunction

    function automatic list_result_t apply_list_cmd(input logic [cllm_pkg::CMD_W-1:0] cmd,
                                                    input logic [cllm_pkg::POS_W-1:0] pos,
                                                    input logic [cllm_pkg::VAL_W-1:0] val);
        list_result_t               r;
        logic [cllm_pkg::POS_W-1:0] n;
        r      = '0;
        r.node = pos;
        case (cmd)
            cllm_pkg::CMD_CREATE, cllm_pkg::CMD_INSERT: begin
                n            = pool_next[0];
                pool_next[0] = pool_next[n];
                if (n == '0) begin
                    r.status = 1'b1;
                    if (cmd == cllm_pkg::CMD_CREATE) r.node = '0;
                end else if (cmd == cllm_pkg::CMD_CREATE) begin
                    pool_next[n] = n;
                    pool_prev[n] = n;
                    head_node    = n;
                    last_node    = n;
                    elem_count   = '0;
                    r.node       = n;
                end else begin
                    pool_elem[n]            = val;
                    pool_next[n]            = pool_next[pos];
                    pool_next[pos]          = n;
                    pool_prev[pool_next[n]] = n;
                    pool_prev[n]            = pos;
                    if (last_node == pos) last_node = n;
                    elem_count = elem_count + 1'b1;
                    r.node     = n;
                end
            end
            cllm_pkg::CMD_FREE: begin
                pool_next[pos] = pool_next[0];
                pool_next[0]   = pos;
            end
            default: begin
                r.elem = pool_elem[pos];
                r.prv  = pool_prev[pos];
                r.nxt  = pool_next[pos];
            end
        endcase
        r.empty   = (head_node == last_node);
        r.is_last = (last_node == pos);
        r.count   = elem_count;
        return r;
    endfunction

    function automatic logic [cllm_pkg::VAL_W-1:0] random_value();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [cllm_pkg::POS_W-1:0] pick_live();
        if (live_nodes.size() == 0) return last_node;
        return live_nodes[$urandom_range(live_nodes.size() - 1)];
    endfunction

    function automatic void drop_live(input logic [cllm_pkg::POS_W-1:0] pos);
        for (int i = 0; i < live_nodes.size(); i++) begin
            if (live_nodes[i] == pos) begin
                live_nodes.delete(i);
                break;
            end
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            if (errors < MAX_REPORTS)
                $error("%s mismatch: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    task automatic send_cmd(input logic [cllm_pkg::CMD_W-1:0] cmd,
                            input logic [cllm_pkg::POS_W-1:0] pos,
                            input logic [cllm_pkg::VAL_W-1:0] val);
        list_result_t r;
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {2'b00, val, pos};
        do @(posedge aclk); while (!s_tready);
        r = apply_list_cmd(cmd, pos, val);
        pending_results.push_back(r);
        cmds_sent++;
        if (r.status) refused_allocs++;
        else if (cmd == cllm_pkg::CMD_CREATE || cmd == cllm_pkg::CMD_INSERT)
            live_nodes.push_back(r.node);
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with no command outstanding: %h", m_tdata);
                errors++;
            end else begin
                want_beat = pending_results.pop_front();
                results_checked++;
                check_field("status", 32'(want_beat.status), 32'(m_tdata[0]));
                check_field("node_index", 32'(want_beat.node), 32'(m_tdata[6:1]));
                check_field("element_value", want_beat.elem, m_tdata[38:7]);
                check_field("prev_node", 32'(want_beat.prv), 32'(m_tdata[44:39]));
                check_field("next_node", 32'(want_beat.nxt), 32'(m_tdata[50:45]));
                check_field("list_empty", 32'(want_beat.empty), 32'(m_tdata[51]));
                check_field("position_is_last", 32'(want_beat.is_last),
                            32'(m_tdata[52]));
                check_field("element_count", 32'(want_beat.count), 32'(m_tdata[58:53]));
            end
        end
    end

    task automatic test_before_create();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_cmd(cllm_pkg::CMD_READ, 6'd0, 32'd0);
        send_cmd(cllm_pkg::CMD_READ, 6'd63, 32'd0);
        send_cmd(cllm_pkg::CMD_INSERT, 6'd5, 32'h0000_0001);
        send_cmd(cllm_pkg::CMD_READ, 6'd5, 32'd0);
    endtask

    task automatic test_pool_exhaustion();
        int tries;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_cmd(cllm_pkg::CMD_CREATE, 6'd0, 32'd0);
        tries = 0;
        while (pool_next[0] != '0 && tries < 80) begin
            send_cmd(cllm_pkg::CMD_INSERT, last_node, random_value());
            tries++;
        end
        send_cmd(cllm_pkg::CMD_INSERT, last_node, 32'h1234_5678);
        send_cmd(cllm_pkg::CMD_CREATE, 6'd9, 32'd0);
        // recycle the tail node so the count runs past its wrap
        repeat (40) begin
            drop_live(last_node);
            send_cmd(cllm_pkg::CMD_FREE, last_node, 32'd0);
            send_cmd(cllm_pkg::CMD_INSERT, last_node, random_value());
        end
        wait_for_drain();
    endtask

    task automatic test_directed_cases();
        logic [cllm_pkg::POS_W-1:0] first;
        logic [cllm_pkg::POS_W-1:0] tail;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int i = 10; i < 16; i++) begin
            drop_live(cllm_pkg::POS_W'(i));
            send_cmd(cllm_pkg::CMD_FREE, cllm_pkg::POS_W'(i), 32'd0);
        end
        send_cmd(cllm_pkg::CMD_CREATE, 6'd63, 32'd0);
        first = head_node;
        send_cmd(cllm_pkg::CMD_INSERT, first, 32'h8000_0000);
        send_cmd(cllm_pkg::CMD_INSERT, last_node, 32'h7fff_ffff);
        send_cmd(cllm_pkg::CMD_INSERT, first, 32'hffff_ffff);
        send_cmd(cllm_pkg::CMD_READ, first, 32'd0);
        send_cmd(cllm_pkg::CMD_READ, pool_next[first], 32'd0);
        send_cmd(cllm_pkg::CMD_READ, last_node, 32'd0);
        tail = last_node;
        drop_live(tail);
        send_cmd(cllm_pkg::CMD_FREE, tail, 32'd0);
        send_cmd(cllm_pkg::CMD_FREE, tail, 32'd0);
        send_cmd(cllm_pkg::CMD_INSERT, tail, 32'h5555_5555);
        send_cmd(cllm_pkg::CMD_FREE, 6'd0, 32'd0);
        send_cmd(cllm_pkg::CMD_INSERT, first, 32'haaaa_aaaa);
        send_cmd(cllm_pkg::CMD_READ, 6'd0, 32'd0);
        send_cmd(cllm_pkg::CMD_CREATE, 6'd0, 32'd0);
        send_cmd(cllm_pkg::CMD_READ, 6'd63, 32'd0);
        send_cmd(cllm_pkg::CMD_READ, tail, 32'd0);
        wait_for_drain();
    endtask

    task automatic test_random_traffic(input int beats, input int idle_pct,
                                       input int stall_pct);
        int                         kind;
        logic [cllm_pkg::CMD_W-1:0] cmd;
        logic [cllm_pkg::POS_W-1:0] pos;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (beats) begin
            if ($urandom_range(99) < 15) begin
                cmd = cllm_pkg::CMD_W'($urandom_range(3));
                pos = cllm_pkg::POS_W'($urandom_range(63));
            end else begin
                kind = $urandom_range(99);
                pos  = pick_live();
                if (kind < 4) begin
                    cmd = cllm_pkg::CMD_CREATE;
                end else if (kind < 45) begin
                    cmd = cllm_pkg::CMD_INSERT;
                    if ($urandom_range(1) == 1) pos = last_node;
                end else if (kind < 62) begin
                    cmd = cllm_pkg::CMD_FREE;
                    drop_live(pos);
                end else begin
                    cmd = cllm_pkg::CMD_READ;
                end
            end
            send_cmd(cmd, pos, random_value());
        end
        wait_for_drain();
    endtask

    initial begin
        aresetn         = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = '0;
        m_tready        = 1'b0;
        errors          = 0;
        cmds_sent       = 0;
        results_checked = 0;
        refused_allocs  = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        reset_pool_model();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        test_before_create();
        test_pool_exhaustion();
        test_directed_cases();
        test_random_traffic(450, 0, 0);
        test_random_traffic(400, 83, 0);
        test_random_traffic(400, 0, 83);
        test_random_traffic(450, 6, 6);

        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Sent %0d commands and checked %0d results; %0d allocations were refused.",
                 cmds_sent, results_checked, refused_allocs);
        $display("Covered misuse before create, pool exhaustion, count wrap and stalls.");
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $error("run stopped at the cycle limit with %0d results outstanding",
               pending_results.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
